### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

### rtl/core/ldt_pkg.sv
// ----------------------------------------------------------------------------
// ldt_pkg
// Types and codes for the loop deck transport controller.
// ----------------------------------------------------------------------------
package ldt_pkg;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_ARMED     = 3'd1,
      ST_RECORDING = 3'd2,
      ST_PLAYING   = 3'd3,
      ST_OVERDUB   = 3'd4,
      ST_STOPPED   = 3'd5
   } deck_state_type;

   typedef enum logic [2:0] {
      PD_NONE   = 3'd0,
      PD_START  = 3'd1,
      PD_STOP   = 3'd2,
      PD_REPLAY = 3'd3,
      PD_CLOSE  = 3'd4
   } pending_type;

   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_RECORD = 3'd1;
   localparam logic [2:0] CMD_PLAY   = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_UNDO   = 3'd4;
   localparam logic [2:0] CMD_HALVE  = 3'd5;
   localparam logic [2:0] CMD_DOUBLE = 3'd6;

   localparam logic MODE_COMMAND  = 1'b0;
   localparam logic MODE_BOUNDARY = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [2:0] command;
      logic       immediate_tap;
      logic       grid_active;
      logic       transport_running;
      logic       take_present;
   } req_word_type;

   typedef struct packed {
      logic       start_record_pulse;
      logic       close_record_pulse;
      logic       restart_play_pulse;
      logic       begin_overdub_pulse;
      logic       end_overdub_pulse;
      logic       clear_pulse;
      logic       undo_pulse;
      logic       halve_pulse;
      logic       double_pulse;
      logic [2:0] deck_state_out;
      logic [2:0] pending_out;
   } rsp_word_type;

endpackage

### rtl/core/loop_deck_transport_fsm_unit.sv
// ----------------------------------------------------------------------------
// loop_deck_transport_fsm_unit
// Transport controller of a loop recorder deck: deck state, one quantized
// pending action, edge pulses per command or grid boundary word.
// ----------------------------------------------------------------------------
// One result word per request word, registered and shown in the cycle after
// acceptance. A new word is taken every cycle while req_stall is low: the
// next-state decode over the deck state and pending registers is combinational,
// and the result register frees each cycle the output side takes its word.
// req_stall rises only while a result is held by rsp_stall.
`include "assert_macros.svh"

module loop_deck_transport_fsm_unit import ldt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   deck_state_type state_ff, state_in;
   pending_type    pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_ff, rsp_in;
   logic           req_accept;
   logic           q_start, q_play, len_ok;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   assign q_start = !req_word.immediate_tap && req_word.grid_active;
   assign q_play  = q_start && req_word.transport_running;
   assign len_ok  = req_word.take_present &&
                    (state_ff == ST_PLAYING || state_ff == ST_OVERDUB ||
                     state_ff == ST_STOPPED);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      rsp_in   = '0;
      if (req_word.mode == MODE_BOUNDARY) begin
         unique case (pend_ff)
            PD_START: begin
               state_in = ST_RECORDING;
               rsp_in.start_record_pulse = 1'b1;
            end
            PD_STOP: state_in = ST_STOPPED;
            PD_REPLAY: begin
               state_in = ST_PLAYING;
               rsp_in.restart_play_pulse = 1'b1;
            end
            PD_CLOSE: begin
               state_in = ST_PLAYING;
               rsp_in.close_record_pulse = 1'b1;
            end
            default: ;
         endcase
         pend_in = PD_NONE;
      end else begin
         unique case (req_word.command)
            CMD_RECORD: begin
               unique case (state_ff)
                  ST_IDLE, ST_STOPPED: begin
                     if (q_start) begin
                        state_in = ST_ARMED;
                        pend_in  = PD_START;
                     end else begin
                        state_in = ST_RECORDING;
                        rsp_in.start_record_pulse = 1'b1;
                     end
                  end
                  ST_ARMED: begin
                     if (req_word.immediate_tap) begin
                        state_in = ST_RECORDING;
                        rsp_in.start_record_pulse = 1'b1;
                     end else begin
                        state_in = req_word.take_present ? ST_STOPPED : ST_IDLE;
                     end
                     pend_in = PD_NONE;
                  end
                  ST_RECORDING: begin
                     if (q_play) begin
                        pend_in = PD_CLOSE;
                     end else begin
                        state_in = ST_PLAYING;
                        rsp_in.close_record_pulse = 1'b1;
                     end
                  end
                  ST_PLAYING: begin
                     if (req_word.take_present) begin
                        state_in = ST_OVERDUB;
                        rsp_in.begin_overdub_pulse = 1'b1;
                     end
                  end
                  ST_OVERDUB: begin
                     state_in = ST_PLAYING;
                     rsp_in.end_overdub_pulse = 1'b1;
                  end
                  default: ;
               endcase
            end
            CMD_PLAY: begin
               unique case (state_ff)
                  ST_RECORDING: begin
                     if (q_play) begin
                        pend_in = PD_CLOSE;
                     end else begin
                        state_in = ST_PLAYING;
                        rsp_in.close_record_pulse = 1'b1;
                     end
                  end
                  ST_PLAYING, ST_OVERDUB: begin
                     if (q_play) pend_in = PD_STOP;
                     else        state_in = ST_STOPPED;
                  end
                  ST_STOPPED: begin
                     if (req_word.take_present) begin
                        if (q_play) begin
                           pend_in = PD_REPLAY;
                        end else begin
                           state_in = ST_PLAYING;
                           rsp_in.restart_play_pulse = 1'b1;
                        end
                     end
                  end
                  ST_ARMED: begin
                     state_in = req_word.take_present ? ST_STOPPED : ST_IDLE;
                     pend_in  = PD_NONE;
                  end
                  default: ;
               endcase
            end
            CMD_CLEAR: begin
               rsp_in.clear_pulse = 1'b1;
               state_in = ST_IDLE;
               pend_in  = PD_NONE;
            end
            CMD_UNDO: begin
               if (req_word.take_present) begin
                  rsp_in.undo_pulse = 1'b1;
                  state_in = ST_PLAYING;
               end
            end
            CMD_HALVE:  rsp_in.halve_pulse  = len_ok;
            CMD_DOUBLE: rsp_in.double_pulse = len_ok;
            default: ;  // no command (code zero) or unused code seven
         endcase
      end
      rsp_in.deck_state_out = state_in;
      rsp_in.pending_out    = pend_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)      rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= PD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
            pend_ff  <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) rsp_ff <= rsp_in;
   end

   // a held result blocks the request side
   `ASSERT_IMPLY(a_stall_back, clock, reset, rsp_valid_ff && rsp_stall, req_stall)
   // the word on display matches the state registers
   `ASSERT_IMPLY(a_state_match, clock, reset, rsp_valid_ff,
      rsp_ff.deck_state_out == state_ff && rsp_ff.pending_out == pend_ff)
   // every word carries at most one edge pulse
   `ASSERT_IMPLY(a_one_pulse, clock, reset, rsp_valid_ff,
      $countones(rsp_ff[14:6]) <= 1)
   // a clear always lands in idle with nothing pending
   `ASSERT_NEXT(a_clear, clock, reset,
      req_accept && req_word.mode == MODE_COMMAND && req_word.command == CMD_CLEAR,
      rsp_valid_ff && rsp_ff.clear_pulse && state_ff == ST_IDLE && pend_ff == PD_NONE)

endmodule

### test/loop_deck_transport_fsm_unit_test.sv
// ----------------------------------------------------------------------------
// loop_deck_transport_fsm_unit_test
// Self-checking bench for the loop deck transport controller. Result words
// are predicted by a behavioral model of the deck state and pending action,
// and every result word is compared against the oldest prediction. Covers a
// directed walk through the transport states, biased random command streams,
// a long output hold-off, and a final run with no idling.
// ----------------------------------------------------------------------------
module loop_deck_transport_fsm_unit_test;
   import ldt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 9;
   localparam int HOLD_CYCLES  = 150;
   localparam int STUCK_LIMIT  = 1000;
   localparam int MAX_REPORTS  = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // model of the deck
   deck_state_type deck_model = ST_IDLE;
   pending_type    pending_model = PD_NONE;
   rsp_word_type   predicted_words[$];

   int  mismatch_count = 0;
   int  stuck_cycles = 0;
   bit  send_gaps = 1'b1;
   bit  recv_gaps = 1'b1;
   bit  hold_off_pending = 1'b0;

   loop_deck_transport_fsm_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the deck model by one word and return the result it should give.
   function automatic rsp_word_type next_deck_word(input req_word_type w);
      rsp_word_type r;
      logic         q_start;
      logic         q_play;
      logic         len_ok;
      r       = '0;
      q_start = !w.immediate_tap && w.grid_active;
      q_play  = q_start && w.transport_running;
      len_ok  = w.take_present &&
                (deck_model inside {ST_PLAYING, ST_OVERDUB, ST_STOPPED});
      if (w.mode == MODE_BOUNDARY) begin
         case (pending_model)
            PD_START: begin
               deck_model = ST_RECORDING;
               r.start_record_pulse = 1'b1;
            end
            PD_STOP:   deck_model = ST_STOPPED;
            PD_REPLAY: begin
               deck_model = ST_PLAYING;
               r.restart_play_pulse = 1'b1;
            end
            PD_CLOSE: begin
               deck_model = ST_PLAYING;
               r.close_record_pulse = 1'b1;
            end
            default: ;
         endcase
         pending_model = PD_NONE;
      end else begin
         case (w.command)
            CMD_RECORD: begin
               case (deck_model)
                  ST_IDLE, ST_STOPPED: begin
                     if (q_start) begin
                        deck_model    = ST_ARMED;
                        pending_model = PD_START;
                     end else begin
                        deck_model = ST_RECORDING;
                        r.start_record_pulse = 1'b1;
                     end
                  end
                  ST_ARMED: begin
                     if (w.immediate_tap) begin
                        deck_model = ST_RECORDING;
                        r.start_record_pulse = 1'b1;
                     end else begin
                        deck_model = w.take_present ? ST_STOPPED : ST_IDLE;
                     end
                     pending_model = PD_NONE;
                  end
                  ST_RECORDING: begin
                     // punch-out, quantized only with transport running
                     if (q_play) pending_model = PD_CLOSE;
                     else begin
                        deck_model = ST_PLAYING;
                        r.close_record_pulse = 1'b1;
                     end
                  end
                  ST_PLAYING: begin
                     if (w.take_present) begin
                        deck_model = ST_OVERDUB;
                        r.begin_overdub_pulse = 1'b1;
                     end
                  end
                  ST_OVERDUB: begin
                     deck_model = ST_PLAYING;
                     r.end_overdub_pulse = 1'b1;
                  end
                  default: ;
               endcase
            end
            CMD_PLAY: begin
               case (deck_model)
                  ST_RECORDING: begin
                     if (q_play) pending_model = PD_CLOSE;
                     else begin
                        deck_model = ST_PLAYING;
                        r.close_record_pulse = 1'b1;
                     end
                  end
                  ST_PLAYING, ST_OVERDUB: begin
                     if (q_play) pending_model = PD_STOP;
                     else deck_model = ST_STOPPED;
                  end
                  ST_STOPPED: begin
                     if (w.take_present) begin
                        if (q_play) pending_model = PD_REPLAY;
                        else begin
                           deck_model = ST_PLAYING;
                           r.restart_play_pulse = 1'b1;
                        end
                     end
                  end
                  ST_ARMED: begin
                     deck_model    = w.take_present ? ST_STOPPED : ST_IDLE;
                     pending_model = PD_NONE;
                  end
                  default: ;
               endcase
            end
            CMD_CLEAR: begin
               r.clear_pulse = 1'b1;
               deck_model    = ST_IDLE;
               pending_model = PD_NONE;
            end
            CMD_UNDO: begin
               if (w.take_present) begin
                  r.undo_pulse = 1'b1;
                  deck_model   = ST_PLAYING;
               end
            end
            CMD_HALVE:  r.halve_pulse  = len_ok;
            CMD_DOUBLE: r.double_pulse = len_ok;
            default: ;
         endcase
      end
      r.deck_state_out = deck_model;
      r.pending_out    = pending_model;
      return r;
   endfunction

   function automatic req_word_type make_word(input logic mode, input logic [2:0] cmd,
                                              input logic imm, input logic grid,
                                              input logic run, input logic take);
      req_word_type w;
      w.mode              = mode;
      w.command           = cmd;
      w.immediate_tap     = imm;
      w.grid_active       = grid;
      w.transport_running = run;
      w.take_present      = take;
      return w;
   endfunction

   // Biased toward record and play/stop so the deck travels through its states;
   // clear is kept rare so it does not keep dropping back to idle.
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      w      = req_word_type'($urandom);
      w.mode = ($urandom_range(0, 3) == 0) ? MODE_BOUNDARY : MODE_COMMAND;
      pick   = $urandom_range(0, 19);
      if (pick < 7) w.command = CMD_RECORD;
      else if (pick < 12) w.command = CMD_PLAY;
      else if (pick == 12) w.command = CMD_CLEAR;
      else if (pick == 13) w.command = CMD_UNDO;
      else if (pick == 14) w.command = CMD_HALVE;
      else if (pick == 15) w.command = CMD_DOUBLE;
      else if (pick == 16) w.command = CMD_NONE;
      else w.command = 3'($urandom_range(0, 7));
      w.immediate_tap = ($urandom_range(0, 3) == 0);
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         req_word  <= req_word_type'($urandom);
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic test_directed_walk();
      req_word_type walk[$];
      walk.push_back(make_word(MODE_COMMAND, CMD_NONE, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_BOUNDARY, CMD_NONE, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_HALVE, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 1, 1, 0));
      walk.push_back(make_word(MODE_BOUNDARY, 3'b111, 1, 1, 1, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_DOUBLE, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_PLAY, 0, 1, 1, 1));
      walk.push_back(make_word(MODE_BOUNDARY, CMD_NONE, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_PLAY, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_PLAY, 1, 1, 1, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_PLAY, 0, 1, 1, 1));
      walk.push_back(make_word(MODE_BOUNDARY, CMD_CLEAR, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_UNDO, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_UNDO, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_HALVE, 0, 0, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, 3'b111, 1, 1, 1, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_CLEAR, 1, 1, 1, 1));
      // quantized start with transport stopped, then cancel with a take
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 1, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 1, 0, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 1, 1, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 1, 1, 1, 1));
      walk.push_back(make_word(MODE_COMMAND, CMD_PLAY, 1, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_CLEAR, 0, 0, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_RECORD, 0, 1, 0, 0));
      walk.push_back(make_word(MODE_COMMAND, CMD_PLAY, 0, 0, 0, 0));
      foreach (walk[i]) send_word(walk[i]);
   endtask

   task automatic test_random_stream(input int count);
      repeat (count) send_word(random_word());
   endtask

   // Output held off for a long stretch while words keep coming.
   task automatic test_output_hold_off();
      send_gaps        = 1'b0;
      hold_off_pending = 1'b1;
      repeat (60) send_word(random_word());
      send_gaps = 1'b1;
   endtask

   task automatic test_full_rate();
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      repeat (120) send_word(random_word());
   endtask

   // receiver: random stall bursts, or one long hold-off on request
   always begin
      @(posedge clock);
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_stall <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 11)) @(posedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predicted_words.push_back(next_deck_word(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected deck word %h at %0t", rsp_word, $realtime);
            end else begin
               want = predicted_words.pop_front();
               if (rsp_word.start_record_pulse  !== want.start_record_pulse  ||
                   rsp_word.close_record_pulse  !== want.close_record_pulse  ||
                   rsp_word.restart_play_pulse  !== want.restart_play_pulse  ||
                   rsp_word.begin_overdub_pulse !== want.begin_overdub_pulse ||
                   rsp_word.end_overdub_pulse   !== want.end_overdub_pulse   ||
                   rsp_word.clear_pulse         !== want.clear_pulse         ||
                   rsp_word.undo_pulse          !== want.undo_pulse          ||
                   rsp_word.halve_pulse         !== want.halve_pulse         ||
                   rsp_word.double_pulse        !== want.double_pulse        ||
                   rsp_word.deck_state_out      !== want.deck_state_out      ||
                   rsp_word.pending_out         !== want.pending_out) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("deck word mismatch at %0t:", $realtime);
                     $display("  expected pulses %b state %0d pending %0d",
                              want[14:6], want.deck_state_out, want.pending_out);
                     $display("  got      pulses %b state %0d pending %0d",
                              rsp_word[14:6], rsp_word.deck_state_out,
                              rsp_word.pending_out);
                  end
               end
            end
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_walk();
      test_random_stream(800);
      test_output_hold_off();
      test_full_rate();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && predicted_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
